FILE: rtl/core/aat_pkg.sv
// Shared types and constants for the box affine transform block.
package aat_pkg;

    localparam int DATA_W   = 32;
    localparam int NUM_AXES = 3;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM_W    = PROD_W + 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    localparam logic [1:0] COL_X = 2'd0;
    localparam logic [1:0] COL_Y = 2'd1;
    localparam logic [1:0] COL_Z = 2'd2;

    typedef logic signed [DATA_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

FILE: rtl/core/aabb_affine_transform.sv
// Top level: Arvo box transform pipeline with matrix column storage.
//
// Usage:
//   Drive an item on the input ports with start high; it is taken at any
//   rising edge where start is high and busy is low. busy stays low, so one
//   item may be issued every cycle.
//   cmd = load writes one output-axis column (three coefficients and the
//   offset); column 3 is dropped. A load gives no result and is seen by
//   every transform issued after it.
//   cmd = transform sends the box through six register stages: capture,
//   multiply (18 products, one 32x32 multiplier each), min/max select,
//   pair add, final add, saturate. The result beat sits on the world_* and
//   saturated ports for exactly one cycle with done high, driven from the
//   saturate stage registers. Throughput is one item per cycle.
//   The receiver cannot stall: every beat must be taken when done is high.
//   Reset (rst_n low) clears the matrix to zero and empties the pipeline;
//   no result is lost or repeated across idle cycles.
module aabb_affine_transform
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [1:0]        column,
    input  logic signed [31:0] coef_from_x,
    input  logic signed [31:0] coef_from_y,
    input  logic signed [31:0] coef_from_z,
    input  logic signed [31:0] offset,
    input  logic signed [31:0] box_min_x,
    input  logic signed [31:0] box_min_y,
    input  logic signed [31:0] box_min_z,
    input  logic signed [31:0] box_max_x,
    input  logic signed [31:0] box_max_y,
    input  logic signed [31:0] box_max_z,
    output logic              done,
    output logic signed [31:0] world_min_x,
    output logic signed [31:0] world_min_y,
    output logic signed [31:0] world_min_z,
    output logic signed [31:0] world_max_x,
    output logic signed [31:0] world_max_y,
    output logic signed [31:0] world_max_z,
    output logic              saturated
);

    localparam sum_t SAT_MAX = sum_t'((sum_t'(1) << (COORD_WIDTH - 1)) - sum_t'(1));
    localparam sum_t SAT_MIN = sum_t'(-SAT_MAX - sum_t'(1));

    logic accept;

    // matrix storage
    coord_t coef_reg [NUM_AXES][NUM_AXES];
    coord_t ofs_reg  [NUM_AXES];

    // stage 1: captured box and matrix
    logic   s1_valid_reg;
    coord_t s1_min_reg  [NUM_AXES];
    coord_t s1_max_reg  [NUM_AXES];
    coord_t s1_coef_reg [NUM_AXES][NUM_AXES];
    coord_t s1_ofs_reg  [NUM_AXES];

    // stage 2: products
    logic   s2_valid_reg;
    prod_t  s2_pa_reg [NUM_AXES][NUM_AXES];
    prod_t  s2_pb_reg [NUM_AXES][NUM_AXES];
    coord_t s2_ofs_reg [NUM_AXES];

    // stage 3: ordered terms
    logic   s3_valid_reg;
    prod_t  s3_lo_reg [NUM_AXES][NUM_AXES];
    prod_t  s3_hi_reg [NUM_AXES][NUM_AXES];
    coord_t s3_ofs_reg [NUM_AXES];

    // stage 4: pair sums
    logic   s4_valid_reg;
    sum_t   s4_lo_a_reg [NUM_AXES];
    sum_t   s4_lo_b_reg [NUM_AXES];
    sum_t   s4_hi_a_reg [NUM_AXES];
    sum_t   s4_hi_b_reg [NUM_AXES];

    // stage 5: full sums
    logic   s5_valid_reg;
    sum_t   s5_lo_reg [NUM_AXES];
    sum_t   s5_hi_reg [NUM_AXES];

    // stage 6: output
    logic   done_reg;
    coord_t out_min_reg [NUM_AXES];
    coord_t out_max_reg [NUM_AXES];
    logic   out_sat_reg;

    coord_t in_min [NUM_AXES];
    coord_t in_max [NUM_AXES];
    coord_t in_coef [NUM_AXES];

    coord_t out_min_next [NUM_AXES];
    coord_t out_max_next [NUM_AXES];
    logic   out_sat_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_min[0]  = box_min_x;
    assign in_min[1]  = box_min_y;
    assign in_min[2]  = box_min_z;
    assign in_max[0]  = box_max_x;
    assign in_max[1]  = box_max_y;
    assign in_max[2]  = box_max_z;
    assign in_coef[0] = coef_from_x;
    assign in_coef[1] = coef_from_y;
    assign in_coef[2] = coef_from_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                ofs_reg[j] <= '0;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    coef_reg[j][i] <= '0;
                end
            end
        end
        else if (accept && cmd == CMD_LOAD)
        begin
            // drop loads aimed past the z column
            for (int j = 0; j < NUM_AXES; j++)
            begin
                if (column == j[1:0])
                begin
                    ofs_reg[j] <= offset;
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        coef_reg[j][i] <= in_coef[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && cmd == CMD_XFORM;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            done_reg     <= s5_valid_reg;
        end
    end

    // payload stages, no reset
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            s1_min_reg[j] <= in_min[j];
            s1_max_reg[j] <= in_max[j];
            s1_ofs_reg[j] <= ofs_reg[j];
            s2_ofs_reg[j] <= s1_ofs_reg[j];
            s3_ofs_reg[j] <= s2_ofs_reg[j];
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s1_coef_reg[j][i] <= coef_reg[j][i];
                s2_pa_reg[j][i] <= (prod_t'(s1_min_reg[i]) * prod_t'(s1_coef_reg[j][i]))
                                   >>> FRAC_BITS;
                s2_pb_reg[j][i] <= (prod_t'(s1_max_reg[i]) * prod_t'(s1_coef_reg[j][i]))
                                   >>> FRAC_BITS;
                if (s2_pa_reg[j][i] < s2_pb_reg[j][i])
                begin
                    s3_lo_reg[j][i] <= s2_pa_reg[j][i];
                    s3_hi_reg[j][i] <= s2_pb_reg[j][i];
                end
                else
                begin
                    s3_lo_reg[j][i] <= s2_pb_reg[j][i];
                    s3_hi_reg[j][i] <= s2_pa_reg[j][i];
                end
            end
            s4_lo_a_reg[j] <= sum_t'(s3_lo_reg[j][0]) + sum_t'(s3_lo_reg[j][1]);
            s4_lo_b_reg[j] <= sum_t'(s3_lo_reg[j][2]) + sum_t'(s3_ofs_reg[j]);
            s4_hi_a_reg[j] <= sum_t'(s3_hi_reg[j][0]) + sum_t'(s3_hi_reg[j][1]);
            s4_hi_b_reg[j] <= sum_t'(s3_hi_reg[j][2]) + sum_t'(s3_ofs_reg[j]);
            s5_lo_reg[j]   <= s4_lo_a_reg[j] + s4_lo_b_reg[j];
            s5_hi_reg[j]   <= s4_hi_a_reg[j] + s4_hi_b_reg[j];
            out_min_reg[j] <= out_min_next[j];
            out_max_reg[j] <= out_max_next[j];
        end
        out_sat_reg <= out_sat_next;
    end

    // clip each sum to the coordinate range, then keep the low field bits
    always_comb
    begin
        out_sat_next = 1'b0;
        for (int j = 0; j < NUM_AXES; j++)
        begin
            if (s5_lo_reg[j] > SAT_MAX)
            begin
                out_min_next[j] = SAT_MAX[DATA_W-1:0];
                out_sat_next    = 1'b1;
            end
            else if (s5_lo_reg[j] < SAT_MIN)
            begin
                out_min_next[j] = SAT_MIN[DATA_W-1:0];
                out_sat_next    = 1'b1;
            end
            else
            begin
                out_min_next[j] = s5_lo_reg[j][DATA_W-1:0];
            end
            if (s5_hi_reg[j] > SAT_MAX)
            begin
                out_max_next[j] = SAT_MAX[DATA_W-1:0];
                out_sat_next    = 1'b1;
            end
            else if (s5_hi_reg[j] < SAT_MIN)
            begin
                out_max_next[j] = SAT_MIN[DATA_W-1:0];
                out_sat_next    = 1'b1;
            end
            else
            begin
                out_max_next[j] = s5_hi_reg[j][DATA_W-1:0];
            end
        end
    end

    assign done        = done_reg;
    assign world_min_x = out_min_reg[COL_X];
    assign world_min_y = out_min_reg[COL_Y];
    assign world_min_z = out_min_reg[COL_Z];
    assign world_max_x = out_max_reg[COL_X];
    assign world_max_y = out_max_reg[COL_Y];
    assign world_max_z = out_max_reg[COL_Z];
    assign saturated   = out_sat_reg;

endmodule
